FILE: hdl/uftk_pkg.sv
// ----------------------------------------------------------------------------
// uftk_pkg: shared types and constants for the union-find top-k engine
// Holds the default sizes, the list count width and the sequencer encodings.
// ----------------------------------------------------------------------------
`default_nettype none

package uftk_pkg;

  // Default number of nodes and length of the per-root top list.
  localparam int NODES_DEF    = 1024;
  localparam int LIST_LEN_DEF = 10;

  // Widths fixed by the beat fields.
  localparam int ID_W    = 10;
  localparam int RANK_W  = 4;
  localparam int CNT_W   = 4;

  // Operation carried by the mode field of an input beat.
  localparam logic MODE_MERGE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_COMP,
    ST_CNT_S,
    ST_CNT_D,
    ST_LOAD,
    ST_FOLD
  } state_e;

  // Which root search is running, or that a query result is being delivered.
  typedef enum logic [1:0] {
    PH_A,
    PH_B,
    PH_Q,
    PH_QOUT
  } phase_e;

endpackage

`default_nettype wire

FILE: hdl/union_find_top_k_query.sv
// ----------------------------------------------------------------------------
// union_find_top_k_query: disjoint-set engine with per-component top-k ids
// Merges components with path compression and answers rank queries.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass, one node per cycle, and takes
// no beat until it ends. An item's beat is then taken in the idle state. Each
// root search walks and then compresses: the walk reads one link per cycle up
// to the root, and the compression pass rewrites one link per cycle and
// closes with a check, all through the single read port of the parent memory.
// A merge searches both nodes; when the roots differ it reads both counts and
// loads both lists, then folds them through the one list memory port and
// stores the new count. A query searches one node and then reads the count
// and the list slot; while an earlier result still waits in the output
// register, it keeps retrying. The input is stalled for the whole of an item.
`default_nettype none

module union_find_top_k_query
  import uftk_pkg::*;
#(
  parameter int NODES    = NODES_DEF,
  parameter int LIST_LEN = LIST_LEN_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire logic              mode_i,
  input  wire logic [ID_W-1:0]   node_a_i,
  input  wire logic [ID_W-1:0]   node_b_i,
  input  wire logic [RANK_W-1:0] rank_i,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      logic              found_o,
  output      logic [ID_W-1:0]   node_id_o
);

  localparam int NW  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LAW = $clog2(NODES * LIST_LEN);
  localparam int SW  = (LIST_LEN > 1) ? $clog2(LIST_LEN) : 1;
  localparam int LDW = $clog2(2 * LIST_LEN + 1);

  // Memories.
  logic [NW-1:0]    parent_mem [NODES];
  logic [CNT_W-1:0] count_mem  [NODES];
  logic [NW-1:0]    list_mem   [NODES*LIST_LEN];

  logic             par_we;
  logic [NW-1:0]    par_wa, par_wd, par_ra, par_rd;
  logic             cnt_we;
  logic [NW-1:0]    cnt_wa, cnt_ra;
  logic [CNT_W-1:0] cnt_wd, cnt_rd;
  logic             lst_we;
  logic [LAW-1:0]   lst_wa, lst_ra;
  logic [NW-1:0]    lst_wd, lst_rd;

  always_ff @(posedge clk_i) begin
    if (par_we) parent_mem[par_wa] <= par_wd;
    par_rd <= parent_mem[par_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) count_mem[cnt_wa] <= cnt_wd;
    cnt_rd <= count_mem[cnt_ra];
  end

  always_ff @(posedge clk_i) begin
    if (lst_we) list_mem[lst_wa] <= lst_wd;
    lst_rd <= list_mem[lst_ra];
  end

  // Control and working registers.
  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [NW-1:0]     cur_q, cur_d, start_q, start_d, root_q, root_d;
  logic [NW-1:0]     ra_q, ra_d, rb_q, rb_d, b_q, b_d, clr_q, clr_d;
  logic [LAW-1:0]    clr_base_q, clr_base_d, sbase_q, sbase_d, dbase_q, dbase_d;
  logic [LAW-1:0]    base_q, base_d;
  logic [RANK_W-1:0] rank_q, rank_d;
  logic              bad_q, bad_d;
  logic [CNT_W-1:0]  ns_q, ns_d, nd_q, nd_d, i_q, i_d, j_q, j_d, n_q, n_d;
  logic [NW-1:0]     last_q, last_d;
  logic [LDW-1:0]    ld_q, ld_d;
  logic [NW-1:0]     sbuf_q [LIST_LEN];
  logic [NW-1:0]     dbuf_q [LIST_LEN];
  logic              buf_we, buf_dst;
  logic [SW-1:0]     buf_idx;
  logic              out_valid_q, out_valid_d, found_q, found_d;
  logic [ID_W-1:0]   id_q, id_d;

  // Input decode.
  logic [31:0]   a_ext, b_ext;
  logic          a_ok, b_ok;
  logic          in_acc;
  assign a_ext  = 32'(node_a_i);
  assign b_ext  = 32'(node_b_i);
  assign a_ok   = a_ext < NODES;
  assign b_ok   = b_ext < NODES;
  assign in_acc = in_valid_i && (state_q == ST_IDLE);

  // Fold step: pick the larger head of the two lists.
  logic [SW-1:0] s_idx, d_idx;
  logic [NW-1:0] sv, dv, fv;
  logic          i_has, j_has, take_s, take_d, push, fold_go;
  assign s_idx   = (i_q < CNT_W'(LIST_LEN)) ? i_q[SW-1:0] : '0;
  assign d_idx   = (j_q < CNT_W'(LIST_LEN)) ? j_q[SW-1:0] : '0;
  assign sv      = sbuf_q[s_idx];
  assign dv      = dbuf_q[d_idx];
  assign i_has   = i_q < ns_q;
  assign j_has   = j_q < nd_q;
  assign take_s  = !j_has || (i_has && (sv > dv));
  assign take_d  = !take_s && (!i_has || (dv > sv));
  assign fv      = take_s ? sv : dv;
  assign push    = (n_q == '0) || (last_q != fv);
  assign fold_go = (n_q < CNT_W'(LIST_LEN)) && (i_has || j_has);

  // Query slot and answer.
  logic [RANK_W-1:0] q_slot;
  logic [31:0]       lst_ext;
  logic              q_found;
  assign q_slot  = ((rank_q != '0) && (rank_q <= RANK_W'(LIST_LEN))) ? rank_q - 1'b1 : '0;
  assign lst_ext = 32'(lst_rd);
  assign q_found = !bad_q && (rank_q != '0) && (CNT_W'(rank_q) <= cnt_rd);

  // Load counter split into source and destination halves.
  logic [LDW-1:0] ld_prev;
  assign ld_prev = ld_q - 1'b1;

  // Next state and memory controls.
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cur_d       = cur_q;
    start_d     = start_q;
    root_d      = root_q;
    ra_d        = ra_q;
    rb_d        = rb_q;
    b_d         = b_q;
    clr_d       = clr_q;
    clr_base_d  = clr_base_q;
    sbase_d     = sbase_q;
    dbase_d     = dbase_q;
    base_d      = base_q;
    rank_d      = rank_q;
    bad_d       = bad_q;
    ns_d        = ns_q;
    nd_d        = nd_q;
    i_d         = i_q;
    j_d         = j_q;
    n_d         = n_q;
    last_d      = last_q;
    ld_d        = ld_q;
    out_valid_d = out_valid_q && out_stall_i;
    found_d     = found_q;
    id_d        = id_q;
    par_we      = 1'b0;
    par_wa      = cur_q;
    par_wd      = root_q;
    par_ra      = cur_q;
    cnt_we      = 1'b0;
    cnt_wa      = rb_q;
    cnt_wd      = n_q;
    cnt_ra      = root_q;
    lst_we      = 1'b0;
    lst_wa      = dbase_q + LAW'(n_q);
    lst_wd      = fv;
    lst_ra      = base_q + LAW'(q_slot);
    buf_we      = 1'b0;
    buf_dst     = 1'b0;
    buf_idx     = '0;

    unique case (state_q)
      // Initialize one node per cycle after reset.
      ST_CLEAR: begin
        par_we     = 1'b1;
        par_wa     = clr_q;
        par_wd     = clr_q;
        cnt_we     = 1'b1;
        cnt_wa     = clr_q;
        cnt_wd     = CNT_W'(1);
        lst_we     = 1'b1;
        lst_wa     = clr_base_q;
        lst_wd     = clr_q;
        clr_d      = clr_q + 1'b1;
        clr_base_d = clr_base_q + LAW'(LIST_LEN);
        if (clr_q == NW'(NODES - 1)) state_d = ST_IDLE;
      end

      // Take a beat and, if its nodes are in range, start the first root walk.
      ST_IDLE: begin
        if (in_acc) begin
          rank_d  = rank_i;
          b_d     = b_ext[NW-1:0];
          cur_d   = a_ext[NW-1:0];
          start_d = a_ext[NW-1:0];
          par_ra  = a_ext[NW-1:0];
          bad_d   = 1'b0;
          if (mode_i == MODE_MERGE) begin
            if (a_ok && b_ok) begin
              phase_d = PH_A;
              state_d = ST_WALK;
            end
          end else if (a_ok) begin
            phase_d = PH_Q;
            state_d = ST_WALK;
          end else begin
            bad_d   = 1'b1;
            phase_d = PH_QOUT;
            state_d = ST_FOLD;
          end
        end
      end

      // Follow parent links until a node points to itself.
      ST_WALK: begin
        if (par_rd == cur_q) begin
          root_d  = cur_q;
          cur_d   = start_q;
          par_ra  = start_q;
          state_d = ST_COMP;
        end else begin
          cur_d  = par_rd;
          par_ra = par_rd;
        end
      end

      // Point every node on the path straight at the root.
      ST_COMP: begin
        if (cur_q != root_q) begin
          par_we = 1'b1;
          par_wa = cur_q;
          par_wd = root_q;
          cur_d  = par_rd;
          par_ra = par_rd;
        end else begin
          priority case (phase_q)
            PH_A: begin
              ra_d    = root_q;
              cur_d   = b_q;
              start_d = b_q;
              par_ra  = b_q;
              phase_d = PH_B;
              state_d = ST_WALK;
            end
            PH_B: begin
              rb_d = root_q;
              if (ra_q == root_q) begin
                state_d = ST_IDLE;
              end else begin
                par_we  = 1'b1;
                par_wa  = ra_q;
                par_wd  = root_q;
                state_d = ST_CNT_S;
              end
            end
            default: begin
              base_d  = LAW'(root_q) * LAW'(LIST_LEN);
              phase_d = PH_QOUT;
              state_d = ST_FOLD;
            end
          endcase
        end
      end

      // Read both list counts.
      ST_CNT_S: begin
        cnt_ra  = ra_q;
        sbase_d = LAW'(ra_q) * LAW'(LIST_LEN);
        dbase_d = LAW'(rb_q) * LAW'(LIST_LEN);
        state_d = ST_CNT_D;
      end

      ST_CNT_D: begin
        cnt_ra  = rb_q;
        ns_d    = cnt_rd;
        i_d     = '0;
        j_d     = '0;
        n_d     = '0;
        ld_d    = '0;
        state_d = ST_LOAD;
      end

      // Copy both lists into local buffers.
      ST_LOAD: begin
        if (ld_q == '0) nd_d = cnt_rd;
        if (ld_q < LDW'(LIST_LEN)) lst_ra = sbase_q + LAW'(ld_q);
        else lst_ra = dbase_q + LAW'(ld_q - LDW'(LIST_LEN));
        if (ld_q != '0) begin
          buf_we = 1'b1;
          if (ld_prev < LDW'(LIST_LEN)) begin
            buf_idx = ld_prev[SW-1:0];
          end else begin
            buf_dst = 1'b1;
            buf_idx = SW'(ld_prev - LDW'(LIST_LEN));
          end
        end
        ld_d = ld_q + 1'b1;
        if (ld_q == LDW'(2 * LIST_LEN)) state_d = ST_FOLD;
      end

      // Merge one entry per cycle, or deliver a query result.
      ST_FOLD: begin
        if (phase_q == PH_QOUT) begin
          cnt_ra = root_q;
          if (!(out_valid_q && out_stall_i)) begin
            out_valid_d = 1'b1;
            found_d     = q_found;
            id_d        = q_found ? lst_ext[ID_W-1:0] : '0;
            state_d     = ST_IDLE;
          end
        end else if (fold_go) begin
          if (take_s) i_d = i_q + 1'b1;
          else if (take_d) j_d = j_q + 1'b1;
          else begin
            i_d = i_q + 1'b1;
            j_d = j_q + 1'b1;
          end
          if (push) begin
            lst_we = 1'b1;
            n_d    = n_q + 1'b1;
            last_d = fv;
          end
        end else begin
          cnt_we  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Query delivery needs two reads settled before the answer, so a wait flag holds it back.
  logic q_wait_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      phase_q     <= PH_A;
      clr_q       <= '0;
      clr_base_q  <= '0;
      out_valid_q <= 1'b0;
      q_wait_q    <= 1'b0;
    end else begin
      // A query enters delivery with its read addresses only just issued, so it first waits.
      if (state_q == ST_FOLD && phase_q == PH_QOUT && !q_wait_q) begin
        q_wait_q <= 1'b1;
      end else begin
        state_q     <= state_d;
        phase_q     <= phase_d;
        q_wait_q    <= 1'b0;
      end
      clr_q       <= clr_d;
      clr_base_q  <= clr_base_d;
      out_valid_q <= (state_q == ST_FOLD && phase_q == PH_QOUT && !q_wait_q)
                     ? (out_valid_q && out_stall_i) : out_valid_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (!(state_q == ST_FOLD && phase_q == PH_QOUT && !q_wait_q)) begin
      cur_q   <= cur_d;
      start_q <= start_d;
      root_q  <= root_d;
      ra_q    <= ra_d;
      rb_q    <= rb_d;
      b_q     <= b_d;
      sbase_q <= sbase_d;
      dbase_q <= dbase_d;
      base_q  <= base_d;
      rank_q  <= rank_d;
      bad_q   <= bad_d;
      ns_q    <= ns_d;
      nd_q    <= nd_d;
      i_q     <= i_d;
      j_q     <= j_d;
      n_q     <= n_d;
      last_q  <= last_d;
      ld_q    <= ld_d;
      found_q <= found_d;
      id_q    <= id_d;
    end
    if (buf_we) begin
      if (buf_dst) dbuf_q[buf_idx] <= lst_rd;
      else sbuf_q[buf_idx] <= lst_rd;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign node_id_o   = id_q;

endmodule

`default_nettype wire

FILE: test/union_find_top_k_query_checker.sv
// ----------------------------------------------------------------------------
// union_find_top_k_query_checker: scoreboard for the union-find top-k engine
// Watches both channels, keeps its own copy of the forest and the per-root top
// lists, predicts every query answer and compares it with the result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module union_find_top_k_query_checker
  import uftk_pkg::*;
#(
  parameter int NODES    = NODES_DEF,
  parameter int LIST_LEN = LIST_LEN_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              mode_i,
  input  logic [ID_W-1:0]   node_a_i,
  input  logic [ID_W-1:0]   node_b_i,
  input  logic [RANK_W-1:0] rank_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic              found_i,
  input  logic [ID_W-1:0]   node_id_i,
  output int                errors_o,
  output int                pending_o
);

  typedef struct packed {
    logic            found;
    logic [ID_W-1:0] node_id;
  } answer_t;

  // Shadow forest and per-root lists.
  logic [ID_W-1:0] parent_q [NODES];
  logic [ID_W-1:0] tops_q   [NODES][LIST_LEN];
  int              count_q  [NODES];
  answer_t         answers_q [$];
  int              errors;
  int              pending;

  assign errors_o  = errors;
  assign pending_o = pending;

  // Root search with full path compression.
  function automatic int find_root(int n);
    int r;
    int cur;
    int nxt;
    int g;
    r = n;
    g = 0;
    while (int'(parent_q[r]) != r && g < NODES) begin
      r = int'(parent_q[r]);
      g++;
    end
    cur = n;
    g = 0;
    while (cur != r && g < NODES) begin
      nxt = int'(parent_q[cur]);
      parent_q[cur] = ID_W'(r);
      cur = nxt;
      g++;
    end
    return r;
  endfunction

  // Merge two descending lists into the destination, dropping repeats.
  function automatic void fold_into(int src, int dst);
    logic [ID_W-1:0] merged [LIST_LEN];
    int n;
    int i;
    int j;
    int ns;
    int nd;
    logic [ID_W-1:0] v;
    n = 0;
    i = 0;
    j = 0;
    ns = (count_q[src] > LIST_LEN) ? LIST_LEN : count_q[src];
    nd = (count_q[dst] > LIST_LEN) ? LIST_LEN : count_q[dst];
    while (n < LIST_LEN && (i < ns || j < nd)) begin
      if (j >= nd || (i < ns && tops_q[src][i] > tops_q[dst][j])) begin
        v = tops_q[src][i];
        i++;
      end else if (i >= ns || tops_q[dst][j] > tops_q[src][i]) begin
        v = tops_q[dst][j];
        j++;
      end else begin
        v = tops_q[dst][j];
        i++;
        j++;
      end
      if (n == 0 || merged[n-1] != v) begin
        merged[n] = v;
        n++;
      end
    end
    for (int k = 0; k < n; k++) tops_q[dst][k] = merged[k];
    count_q[dst] = n;
  endfunction

  // Apply one input beat and queue the answer of a query.
  function automatic void apply_item(logic m, int a, int b, int r);
    int ra;
    int rb;
    int cnt;
    answer_t ans;
    ans = '0;
    if (m == MODE_MERGE) begin
      if (a < NODES && b < NODES) begin
        ra = find_root(a);
        rb = find_root(b);
        if (ra != rb) begin
          parent_q[ra] = ID_W'(rb);
          fold_into(ra, rb);
        end
      end
    end else begin
      if (a < NODES) begin
        ra = find_root(a);
        cnt = (count_q[ra] > LIST_LEN) ? LIST_LEN : count_q[ra];
        if (r >= 1 && r <= cnt) begin
          ans.found   = 1'b1;
          ans.node_id = tops_q[ra][r-1];
        end
      end
      answers_q.push_back(ans);
    end
  endfunction

  // Reset the shadow state, then sample both channels at each rising edge.
  always @(posedge clk_i) begin
    answer_t exp_a;
    if (!rst_ni) begin
      errors = 0;
      answers_q.delete();
      for (int k = 0; k < NODES; k++) begin
        parent_q[k] = ID_W'(k);
        count_q[k]  = 1;
        for (int s = 0; s < LIST_LEN; s++) tops_q[k][s] = '0;
        tops_q[k][0] = ID_W'(k);
      end
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (answers_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result beat: found=%0d node_id=%0d", found_i, node_id_i);
        end else begin
          exp_a = answers_q.pop_front();
          if (exp_a.found !== found_i || exp_a.node_id !== node_id_i) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected found=%0d node_id=%0d, got found=%0d node_id=%0d",
                       exp_a.found, exp_a.node_id, found_i, node_id_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        apply_item(mode_i, int'(node_a_i), int'(node_b_i), int'(rank_i));
    end
    pending = answers_q.size();
  end

endmodule

FILE: test/union_find_top_k_query_tb.sv
// ----------------------------------------------------------------------------
// union_find_top_k_query_tb: stimulus and verdict for the union-find engine
// Drives directed and random merge and query beats through four idling
// phases; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module union_find_top_k_query_tb
  import uftk_pkg::*;
();

  localparam int   IDLE_LIMIT = 40000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              mode = 1'b0;
  logic [ID_W-1:0]   node_a = '0;
  logic [ID_W-1:0]   node_b = '0;
  logic [RANK_W-1:0] rank = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              found;
  logic [ID_W-1:0]   node_id;
  int                errors;
  int                pending;
  int                idle_pct = 0;
  int                stall_pct = 0;
  int                quiet_cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  union_find_top_k_query dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .mode_i(mode), .node_a_i(node_a), .node_b_i(node_b), .rank_i(rank),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .found_o(found), .node_id_o(node_id)
  );

  union_find_top_k_query_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .mode_i(mode), .node_a_i(node_a), .node_b_i(node_b), .rank_i(rank),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .found_i(found), .node_id_i(node_id),
    .errors_o(errors), .pending_o(pending)
  );

  // Receiver back-pressure.
  always @(posedge clk_i) out_stall <= ($urandom_range(99) < stall_pct);

  // Watchdog on cycles with no accepted beat on either channel.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Present one beat and hold it until it is taken.
  task automatic send_item(input logic m, input int a, input int b, input int r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    mode     <= m;
    node_a   <= ID_W'(a);
    node_b   <= ID_W'(b);
    rank     <= RANK_W'(r);
    do @(posedge clk_i); while (in_stall);
  endtask

  // Hold the input off until every queued answer has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int base;
    int a;
    int b;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: fresh nodes, rank edges, chains.
    send_item(MODE_QUERY, 0, 1023, 1);
    send_item(MODE_QUERY, 1023, 0, 1);
    send_item(MODE_QUERY, 5, 0, 2);
    send_item(MODE_QUERY, 5, 0, 0);
    send_item(MODE_QUERY, 5, 1023, 15);
    for (int k = 0; k < 11; k++) send_item(MODE_MERGE, 1023 - k, 1012 - k, 0);
    send_item(MODE_MERGE, 1023, 1001, 0);
    send_item(MODE_MERGE, 0, 1023, 0);
    send_item(MODE_QUERY, 1001, 0, 1);
    send_item(MODE_QUERY, 1023, 0, 10);
    send_item(MODE_QUERY, 0, 0, 11);
    send_item(MODE_QUERY, 0, 0, 0);
    send_item(MODE_MERGE, 1, 0, 15);
    send_item(MODE_QUERY, 1, 0, 10);
    drain();

    // Random part in four idling phases.
    base = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      for (int n = 0; n < 320; n++) begin
        if (n % 80 == 0) base = $urandom_range(1023 - 40);
        if ($urandom_range(9) == 0) begin
          a = $urandom_range(1023);
          b = $urandom_range(1023);
        end else begin
          a = base + $urandom_range(40);
          b = base + $urandom_range(40);
        end
        if ($urandom_range(99) < 55) send_item(MODE_MERGE, a, b, $urandom_range(15));
        else send_item(MODE_QUERY, a, $urandom_range(1023), $urandom_range(15));
      end
      drain();
    end

    stall_pct = 0;
    repeat (3000) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
